### sv/bsfg_pkg.sv
package bsfg_pkg;

   localparam int FRAME_BYTES = 12;

   localparam logic [2:0] REG_CELL_HIGH = 3'd0;
   localparam logic [2:0] REG_CELL_LOW  = 3'd1;
   localparam logic [2:0] REG_SOC_HIGH  = 3'd2;
   localparam logic [2:0] REG_SOC_LOW   = 3'd3;
   localparam logic [2:0] REG_COLD      = 3'd4;
   localparam logic [2:0] REG_ASSIST    = 3'd5;
   localparam logic [2:0] REG_REGEN     = 3'd6;

   localparam logic [15:0] CELL_HIGH_RESET = 16'd42000;
   localparam logic [15:0] CELL_LOW_RESET  = 16'd30000;
   localparam logic [6:0]  SOC_HIGH_RESET  = 7'd85;
   localparam logic [6:0]  SOC_LOW_RESET   = 7'd10;
   localparam logic [7:0]  COLD_RESET      = 8'd2;
   localparam logic [7:0]  ASSIST_RESET    = 8'd16;
   localparam logic [7:0]  REGEN_RESET     = 8'd32;

   localparam logic [7:0] TYPE_STATUS = 8'h87;
   localparam logic [7:0] TYPE_FLAGS  = 8'hAA;
   localparam logic [9:0] SOC_FULL    = 10'd820;
   localparam logic [9:0] SOC_EMPTY   = 10'd200;
   localparam logic [7:0] B4_CRANK    = 8'd24;

   localparam logic [9:0] SOC_ROM [0:100] = '{
        10'd0,   10'd22,  10'd44,  10'd67,  10'd89,  10'd111, 10'd133, 10'd156, 10'd178, 10'd190,
      10'd200, 10'd209, 10'd217, 10'd225, 10'd232, 10'd240, 10'd248, 10'd256, 10'd264, 10'd272,
      10'd279, 10'd287, 10'd295, 10'd303, 10'd311, 10'd319, 10'd326, 10'd334, 10'd342, 10'd350,
      10'd355, 10'd363, 10'd375, 10'd387, 10'd399, 10'd411, 10'd423, 10'd435, 10'd447, 10'd459,
      10'd471, 10'd483, 10'd495, 10'd507, 10'd519, 10'd532, 10'd544, 10'd556, 10'd568, 10'd580,
      10'd592, 10'd604, 10'd616, 10'd628, 10'd640, 10'd652, 10'd664, 10'd676, 10'd688, 10'd700,
      10'd701, 10'd705, 10'd709, 10'd713, 10'd717, 10'd721, 10'd725, 10'd728, 10'd732, 10'd736,
      10'd740, 10'd744, 10'd748, 10'd752, 10'd756, 10'd760, 10'd764, 10'd768, 10'd772, 10'd775,
      10'd779, 10'd783, 10'd787, 10'd791, 10'd795, 10'd799, 10'd800, 10'd814, 10'd829, 10'd843,
      10'd857, 10'd871, 10'd886, 10'd900, 10'd914, 10'd929, 10'd943, 10'd957, 10'd971, 10'd986,
      10'd1000
   };

   typedef logic [FRAME_BYTES-1:0][7:0] frame_type;

   typedef struct packed {
      logic        resync;
      logic [15:0] high_cell_mv;
      logic [15:0] low_cell_mv;
      logic [6:0]  soc_percent;
      logic [7:0]  battery_temp;
      logic [7:0]  mcm_b3;
      logic [7:0]  mcm_b4;
      logic [10:0] current_deciamps;
      logic [7:0]  pack_volts;
   } item_type;

   typedef struct packed {
      logic [15:0] cell_high_limit;
      logic [15:0] cell_low_limit;
      logic [6:0]  soc_high_limit;
      logic [6:0]  soc_low_limit;
      logic [7:0]  cold_limit;
      logic [7:0]  assist_off_bit;
      logic [7:0]  regen_off_bit;
   } cfg_type;

   typedef struct packed {
      logic        next_is_aa;
      logic [10:0] last_soc;
   } state_type;

   function automatic logic [9:0] soc_lookup(input logic [6:0] pct);
      logic [6:0] idx;
      idx = (pct > 7'd100) ? 7'd100 : pct;
      return SOC_ROM[idx];
   endfunction

endpackage

### sv/bsfg_frame_build.sv
module bsfg_frame_build (
   input  bsfg_pkg::item_type  item,
   input  bsfg_pkg::cfg_type   cfg,
   input  bsfg_pkg::state_type state,
   output bsfg_pkg::frame_type frame,
   output bsfg_pkg::state_type state_next
);
   import bsfg_pkg::*;

   logic        full;
   logic        empty;
   logic        cold;
   logic [13:0] code;
   logic [6:0]  ihi;
   logic [6:0]  ilo;
   logic [8:0]  temp_ofs;
   logic [7:0]  temp_byte;
   logic [9:0]  rom_val;
   logic [9:0]  target;
   logic [10:0] soc;
   logic [7:0]  flags;
   logic [7:0]  charge;
   logic [7:0]  sum;
   frame_type   body;

   assign full  = (item.high_cell_mv >= cfg.cell_high_limit) ||
                  (item.soc_percent >= cfg.soc_high_limit);
   assign empty = (item.low_cell_mv <= cfg.cell_low_limit) ||
                  (item.soc_percent <= cfg.soc_low_limit);
   assign cold  = $signed(item.battery_temp) < $signed(cfg.cold_limit);

   assign code = 14'd2048 - {{2{item.current_deciamps[10]}}, item.current_deciamps, 1'b0};
   assign ihi  = code[13:7];
   assign ilo  = code[6:0];

   assign temp_ofs  = $signed({item.battery_temp[7], item.battery_temp}) + 9'sd30;
   assign temp_byte = ($signed(temp_ofs) < 9'sd55) ? 8'd55 : temp_ofs[7:0];

   assign rom_val = soc_lookup(item.soc_percent);
   assign target  = full ? SOC_FULL : (empty ? SOC_EMPTY : rom_val);

   always_comb begin
      if ({1'b0, target} > state.last_soc) begin
         soc = state.last_soc + 11'd1;
      end else if ({1'b0, target} < state.last_soc) begin
         soc = state.last_soc - 11'd1;
      end else begin
         soc = state.last_soc;
      end
   end

   always_comb begin
      flags = 8'd0;
      if (empty) begin
         flags = flags | cfg.assist_off_bit;
      end
      if (full || (cold && !empty)) begin
         flags = flags | cfg.regen_off_bit;
      end
      if ((item.mcm_b4 == B4_CRANK) || (item.mcm_b4 == 8'd0)) begin
         charge = empty ? 8'h20 : 8'h00;
      end else begin
         charge = 8'h12 | (empty ? 8'h20 : 8'h00) | (full ? 8'h40 : 8'h00);
      end
   end

   always_comb begin
      body = '0;
      if (!state.next_is_aa) begin
         body[0]  = TYPE_STATUS;
         body[1]  = 8'h40;
         body[2]  = {1'b0, item.pack_volts[7:1]};
         body[3]  = {4'b0001, soc[10:7]};
         body[4]  = {1'b0, soc[6:0]};
         body[5]  = {1'b0, ihi};
         body[6]  = {1'b0, ilo};
         body[7]  = 8'h32;
         body[8]  = temp_byte;
         body[9]  = temp_byte;
         body[10] = item.mcm_b3;
      end else begin
         body[0]  = TYPE_FLAGS;
         body[1]  = 8'h10;
         body[5]  = flags;
         body[6]  = charge;
         body[7]  = 8'h61;
         body[8]  = {1'b0, ihi};
         body[9]  = {1'b0, ilo};
         body[10] = item.mcm_b4;
      end
   end

   always_comb begin
      sum = 8'd0;
      for (int i = 0; i < FRAME_BYTES - 1; i++) begin
         sum = sum + body[i];
      end
      frame = body;
      frame[FRAME_BYTES-1] = {1'b0, 7'd0 - sum[6:0]};
   end

   always_comb begin
      state_next = state;
      if (item.resync) begin
         state_next.last_soc = {1'b0, rom_val};
      end else begin
         state_next.next_is_aa = !state.next_is_aa;
         if (!state.next_is_aa) begin
            state_next.last_soc = soc;
         end
      end
   end

endmodule

### sv/bsfg_serializer.sv
module bsfg_serializer (
   input  logic                clock,
   input  logic                reset,
   input  logic                load_valid,
   input  bsfg_pkg::frame_type load_frame,
   output logic                load_ready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast
);
   import bsfg_pkg::*;

   localparam int CntW = $clog2(FRAME_BYTES);
   localparam logic [CntW-1:0] LastCnt = CntW'(FRAME_BYTES - 1);

   logic            pend_valid_ff, pend_valid_in;
   frame_type       pend_ff, pend_in;
   logic            out_valid_ff, out_valid_in;
   frame_type       out_ff, out_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            fire;
   logic            done;
   logic            take;

   assign fire = out_valid_ff && rsp_tready;
   assign done = fire && (cnt_ff == LastCnt);
   assign take = pend_valid_ff && (!out_valid_ff || done);
   assign load_ready = !pend_valid_ff;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      cnt_in        = cnt_ff;
      if (fire) begin
         out_in = {8'd0, out_ff[FRAME_BYTES-1:1]};
         cnt_in = cnt_ff + 1'b1;
      end
      if (done) begin
         out_valid_in = 1'b0;
      end
      if (take) begin
         out_valid_in  = 1'b1;
         out_in        = pend_ff;
         cnt_in        = '0;
         pend_valid_in = 1'b0;
      end
      if (load_valid && load_ready) begin
         pend_valid_in = 1'b1;
         pend_in       = load_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         cnt_ff        <= cnt_in;
      end
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff[0];
   assign rsp_tlast  = (cnt_ff == LastCnt);

endmodule

### sv/battery_status_frame_generator_top.sv
// battery status frame generator
// req channel: one word per frame tick; tuser set marks a resync word, which
//   reloads the stored soc from the remap table of soc_percent and sends nothing
// rsp channel: each tick word yields a 12-byte frame, one byte per word,
//   tlast on the checksum byte; frames alternate 0x87 and 0xAA, 0x87 first
// csr port: csr_we writes csr_wdata into register csr_addr at the clock edge;
//   write only while no word is in flight
// latency: the first byte of a frame is valid two cycles after the req word
//   is taken, when the output is free
// throughput: one frame per 12 cycles, set by the one-byte-per-cycle output;
//   a finished frame waits in a holding register while the previous one drains,
//   so a new req word is taken as soon as that holding slot frees
// resync words are taken one per cycle
// when rsp_tready is low the current byte holds and req_tready drops once the
//   input and holding registers are both full
// reset: synchronous; clears the frame parity to 0x87, stored soc to zero and
//   the registers to their defaults
module battery_status_frame_generator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // high_cell_mv, low_cell_mv, soc_percent, battery_temp, mcm_b3, mcm_b4,
   // current_deciamps, pack_volts, zero pad
   input  logic [87:0] req_tdata,
   // resync
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // frame_byte
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [15:0] csr_wdata
);
   import bsfg_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   state_type state_ff, state_next;
   logic      in_valid_ff, in_valid_in;
   item_type  in_ff, in_in;
   frame_type frame;
   logic      load_ready;
   logic      advance;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_CELL_HIGH: cfg_in.cell_high_limit = csr_wdata;
            REG_CELL_LOW:  cfg_in.cell_low_limit  = csr_wdata;
            REG_SOC_HIGH:  cfg_in.soc_high_limit  = csr_wdata[6:0];
            REG_SOC_LOW:   cfg_in.soc_low_limit   = csr_wdata[6:0];
            REG_COLD:      cfg_in.cold_limit      = csr_wdata[7:0];
            REG_ASSIST:    cfg_in.assist_off_bit  = csr_wdata[7:0];
            REG_REGEN:     cfg_in.regen_off_bit   = csr_wdata[7:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   assign advance    = in_valid_ff && (in_ff.resync || load_ready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         in_valid_in               = 1'b1;
         in_in.resync              = req_tuser;
         in_in.high_cell_mv        = req_tdata[15:0];
         in_in.low_cell_mv         = req_tdata[31:16];
         in_in.soc_percent         = req_tdata[38:32];
         in_in.battery_temp        = req_tdata[46:39];
         in_in.mcm_b3              = req_tdata[54:47];
         in_in.mcm_b4              = req_tdata[62:55];
         in_in.current_deciamps    = req_tdata[73:63];
         in_in.pack_volts          = req_tdata[81:74];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cell_high_limit <= CELL_HIGH_RESET;
         cfg_ff.cell_low_limit  <= CELL_LOW_RESET;
         cfg_ff.soc_high_limit  <= SOC_HIGH_RESET;
         cfg_ff.soc_low_limit   <= SOC_LOW_RESET;
         cfg_ff.cold_limit      <= COLD_RESET;
         cfg_ff.assist_off_bit  <= ASSIST_RESET;
         cfg_ff.regen_off_bit   <= REGEN_RESET;
         state_ff               <= '0;
         in_valid_ff            <= 1'b0;
      end else begin
         cfg_ff      <= cfg_in;
         in_valid_ff <= in_valid_in;
         if (advance) begin
            state_ff <= state_next;
         end
      end
      in_ff <= in_in;
   end

   bsfg_frame_build u_build (
      .item       (in_ff),
      .cfg        (cfg_ff),
      .state      (state_ff),
      .frame      (frame),
      .state_next (state_next)
   );

   bsfg_serializer u_ser (
      .clock      (clock),
      .reset      (reset),
      .load_valid (in_valid_ff && !in_ff.resync),
      .load_frame (frame),
      .load_ready (load_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_resync_keeps_parity: assert property (@(posedge clock) disable iff (reset)
      (advance && in_ff.resync) |=> $stable(state_ff.next_is_aa))
      else $error("resync changed frame parity");

   a_tick_flips_parity: assert property (@(posedge clock) disable iff (reset)
      (advance && !in_ff.resync) |=> (state_ff.next_is_aa != $past(state_ff.next_is_aa)))
      else $error("frame tick did not flip frame parity");

   a_soc_slew: assert property (@(posedge clock) disable iff (reset)
      (advance && !in_ff.resync && !state_ff.next_is_aa) |=>
      ((state_ff.last_soc == $past(state_ff.last_soc)) ||
       (state_ff.last_soc == $past(state_ff.last_soc) + 11'd1) ||
       (state_ff.last_soc == $past(state_ff.last_soc) - 11'd1)))
      else $error("soc moved by more than one step");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && !in_ff.resync && !load_ready))
      else $error("input stalled without a full pipeline");

endmodule
